// ----- hdl/cfb_pkg.sv -----
// Shared types, constants and the CRC byte update for the Format A frame builder.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package cfb_pkg;

  // CRC-16 generator, MSB first, register starts at zero
  localparam logic [15:0] CRC_POLY = 16'h3D65;

  // L-field adds the fixed header length to the payload count
  localparam logic [7:0] L_FIXED = 8'd10;

  // fill count at which the next payload byte closes a block
  localparam logic [4:0] BLOCK_LAST_FILL = 5'd15;

  // reset value of the C-field
  localparam logic [7:0] CTRL_RESET = 8'h44;

  // byte kinds on the result side
  localparam logic [1:0] KIND_HDR     = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_CRC     = 2'd2;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_CONTROL = 3'd0,
    CFG_MANUF   = 3'd1,
    CFG_DEV_ID  = 3'd2,
    CFG_VERSION = 3'd3,
    CFG_DEVKIND = 3'd4,
    CFG_CI      = 3'd5
  } cfb_cfg_idx_e;

  // request classes after decode
  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } cfb_op_e;

  // one input request as it arrives
  typedef struct packed {
    logic       cmd;
    logic [7:0] body_len;
    logic [7:0] data_byte;
  } cfb_in_t;

  // one decoded request waiting for the back end
  typedef struct packed {
    cfb_op_e    op;
    logic [7:0] len;
    logic [7:0] lfield;
    logic [7:0] data;
  } cfb_req_t;

  // one result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic       run_last;
    logic       frame_done;
    logic       error_flag;
  } cfb_out_t;

  // address and control fields of the frame
  typedef struct packed {
    logic [7:0]  control_field;
    logic [15:0] manufacturer_code;
    logic [31:0] device_id;
    logic [7:0]  version_byte;
    logic [7:0]  device_kind;
    logic [7:0]  ci_byte;
  } cfb_cfg_t;

  // advance the CRC register by one byte, MSB first
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- hdl/block_crc_frame_builder.sv -----
// Top level of the wireless M-Bus Format A frame builder: configuration registers and wiring.
// Depends on cfb_pkg, cfb_front, cfb_back and cfb_resq.
//
// A start request produces the ten header bytes, their complemented CRC-16 (0x3D65, high byte
// first) and the CI byte: 13 results, or 15 when the payload length is zero and the CI block is
// closed at once. A data request produces its payload byte, followed by a CRC pair when it
// completes a block (CI plus 15 bytes, then 16 bytes, or the end of the frame): 1 or 3 results.
// A data request with no open frame yields a single error result. The back-end sequencer emits
// one result per clock while a request waits and the result queue has room; plain payload bytes
// then sustain one request per cycle. An input queue of InDepth requests and a result queue of
// OutDepth results decouple the two sides, so input keeps flowing while results wait to be
// popped. Both depths must be at least 2. Configuration writes are always accepted and should
// only be issued while no frame bytes are in flight; reset loads the configuration defaults.
module block_crc_frame_builder #(
  parameter int unsigned InDepth  = 2,
  parameter int unsigned OutDepth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  cfb_pkg::cfb_in_t  in_item_i,
  output logic              empty,
  input  logic              pop,
  output cfb_pkg::cfb_out_t res_item_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  cfb_pkg::cfb_cfg_t cfg_q;
  logic              req_valid, req_pop;
  cfb_pkg::cfb_req_t req;
  logic              res_push, res_full;
  cfb_pkg::cfb_out_t res;

  assign cfg_ready_o = 1'b1;

  // write configuration registers; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.control_field     <= cfb_pkg::CTRL_RESET;
      cfg_q.manufacturer_code <= '0;
      cfg_q.device_id         <= '0;
      cfg_q.version_byte      <= '0;
      cfg_q.device_kind       <= '0;
      cfg_q.ci_byte           <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfb_pkg::cfb_cfg_idx_e'(cfg_index_i))
        cfb_pkg::CFG_CONTROL: cfg_q.control_field     <= cfg_data_i[7:0];
        cfb_pkg::CFG_MANUF:   cfg_q.manufacturer_code <= cfg_data_i[15:0];
        cfb_pkg::CFG_DEV_ID:  cfg_q.device_id         <= cfg_data_i;
        cfb_pkg::CFG_VERSION: cfg_q.version_byte      <= cfg_data_i[7:0];
        cfb_pkg::CFG_DEVKIND: cfg_q.device_kind       <= cfg_data_i[7:0];
        cfb_pkg::CFG_CI:      cfg_q.ci_byte           <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  cfb_front #(
    .Depth(InDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .item_i      (in_item_i),
    .full        (full),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_pop_i   (req_pop)
  );

  cfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_pop_o   (req_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  cfb_resq #(
    .Depth(OutDepth)
  ) u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .item_i (res),
    .full_o (res_full),
    .empty  (empty),
    .item_o (res_item_o),
    .pop    (pop)
  );

endmodule

// ----- hdl/cfb_front.sv -----
// Front end: input request queue with decode of each request into a start or data operation.
// Depends on cfb_pkg.
module cfb_front #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  cfb_pkg::cfb_in_t  item_i,
  output logic              full,
  output logic              req_valid_o,
  output cfb_pkg::cfb_req_t req_o,
  input  logic              req_pop_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cfb_pkg::cfb_req_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              wr_en, rd_en;
  cfb_pkg::cfb_req_t dec;

  assign full        = (cnt_q == CntW'(Depth));
  assign req_valid_o = (cnt_q != '0);
  assign wr_en       = push & ~full;
  assign rd_en       = req_pop_i & req_valid_o;
  assign req_o       = mem_q[rd_ptr_q];

  // decode the request and precompute the L-field
  always_comb begin
    dec.op     = item_i.cmd ? cfb_pkg::OP_DATA : cfb_pkg::OP_START;
    dec.len    = item_i.body_len;
    dec.lfield = item_i.body_len + cfb_pkg::L_FIXED;
    dec.data   = item_i.data_byte;
  end

  // advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // store the decoded request
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= dec;
    end
  end

endmodule

// ----- hdl/cfb_back.sv -----
// Back end: frame sequencer that expands each request into frame bytes and inserts CRC pairs.
// Depends on cfb_pkg; feeds the result queue one byte per cycle while requested and not full.
module cfb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfb_pkg::cfb_cfg_t cfg_i,
  input  logic              req_valid_i,
  input  cfb_pkg::cfb_req_t req_i,
  output logic              req_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output cfb_pkg::cfb_out_t res_o
);

  // steps of a start request
  localparam logic [3:0] ST_LEN     = 4'd0;
  localparam logic [3:0] ST_CTRL    = 4'd1;
  localparam logic [3:0] ST_MAN_LO  = 4'd2;
  localparam logic [3:0] ST_MAN_HI  = 4'd3;
  localparam logic [3:0] ST_ID0     = 4'd4;
  localparam logic [3:0] ST_ID1     = 4'd5;
  localparam logic [3:0] ST_ID2     = 4'd6;
  localparam logic [3:0] ST_ID3     = 4'd7;
  localparam logic [3:0] ST_VER     = 4'd8;
  localparam logic [3:0] ST_KIND    = 4'd9;
  localparam logic [3:0] ST_HCRC_HI = 4'd10;
  localparam logic [3:0] ST_HCRC_LO = 4'd11;
  localparam logic [3:0] ST_CI      = 4'd12;
  localparam logic [3:0] ST_ECRC_HI = 4'd13;
  localparam logic [3:0] ST_ECRC_LO = 4'd14;

  // steps of a data request
  localparam logic [3:0] DT_PAYLOAD = 4'd0;
  localparam logic [3:0] DT_CRC_HI  = 4'd1;
  localparam logic [3:0] DT_CRC_LO  = 4'd2;

  logic [3:0]  step_q;
  logic [15:0] crc_q;
  logic [7:0]  left_q;
  logic [4:0]  fill_q;
  logic        open_q;

  logic              fire;
  logic [15:0]       crc_n;
  logic [15:0]       crc_base;
  logic              upd_crc, clr_crc;
  logic              open_frame, close_frame, count_byte, end_block;
  logic              close_blk;
  cfb_pkg::cfb_out_t res;

  assign fire       = req_valid_i & ~res_full_i;
  assign res_push_o = fire;
  assign req_pop_o  = fire & res.run_last;
  assign res_o      = res;
  assign crc_n      = ~crc_q;

  // restart the CRC on the first header byte
  assign crc_base = (req_i.op == cfb_pkg::OP_START && step_q == ST_LEN) ? '0 : crc_q;

  // select the byte for this step and the state actions it carries
  always_comb begin
    res         = '0;
    upd_crc     = 1'b0;
    clr_crc     = 1'b0;
    open_frame  = 1'b0;
    close_frame = 1'b0;
    count_byte  = 1'b0;
    end_block   = 1'b0;
    close_blk   = 1'b0;
    if (req_i.op == cfb_pkg::OP_START) begin
      res.byte_kind = cfb_pkg::KIND_HDR;
      case (step_q)
        ST_LEN: begin
          res.out_byte = req_i.lfield;
          upd_crc      = 1'b1;
        end
        ST_CTRL: begin
          res.out_byte = cfg_i.control_field;
          upd_crc      = 1'b1;
        end
        ST_MAN_LO: begin
          res.out_byte = cfg_i.manufacturer_code[7:0];
          upd_crc      = 1'b1;
        end
        ST_MAN_HI: begin
          res.out_byte = cfg_i.manufacturer_code[15:8];
          upd_crc      = 1'b1;
        end
        ST_ID0: begin
          res.out_byte = cfg_i.device_id[7:0];
          upd_crc      = 1'b1;
        end
        ST_ID1: begin
          res.out_byte = cfg_i.device_id[15:8];
          upd_crc      = 1'b1;
        end
        ST_ID2: begin
          res.out_byte = cfg_i.device_id[23:16];
          upd_crc      = 1'b1;
        end
        ST_ID3: begin
          res.out_byte = cfg_i.device_id[31:24];
          upd_crc      = 1'b1;
        end
        ST_VER: begin
          res.out_byte = cfg_i.version_byte;
          upd_crc      = 1'b1;
        end
        ST_KIND: begin
          res.out_byte = cfg_i.device_kind;
          upd_crc      = 1'b1;
        end
        ST_HCRC_HI, ST_ECRC_HI: begin
          res.out_byte  = crc_n[15:8];
          res.byte_kind = cfb_pkg::KIND_CRC;
        end
        ST_HCRC_LO: begin
          res.out_byte  = crc_n[7:0];
          res.byte_kind = cfb_pkg::KIND_CRC;
          clr_crc       = 1'b1;
        end
        ST_CI: begin
          res.out_byte = cfg_i.ci_byte;
          upd_crc      = 1'b1;
          open_frame   = 1'b1;
          res.run_last = (req_i.len != '0);
        end
        ST_ECRC_LO: begin
          res.out_byte   = crc_n[7:0];
          res.byte_kind  = cfb_pkg::KIND_CRC;
          res.frame_done = 1'b1;
          res.run_last   = 1'b1;
          clr_crc        = 1'b1;
          close_frame    = 1'b1;
        end
        default: begin
          res.run_last = 1'b1;
        end
      endcase
    end else if (!open_q) begin
      // data with no open frame: flag it, leave state alone
      res.error_flag = 1'b1;
      res.run_last   = 1'b1;
    end else begin
      case (step_q)
        DT_PAYLOAD: begin
          res.out_byte  = req_i.data;
          res.byte_kind = cfb_pkg::KIND_PAYLOAD;
          upd_crc       = 1'b1;
          count_byte    = 1'b1;
          close_blk     = (left_q == 8'd1) || (fill_q >= cfb_pkg::BLOCK_LAST_FILL);
          res.run_last  = ~close_blk;
        end
        DT_CRC_HI: begin
          res.out_byte  = crc_n[15:8];
          res.byte_kind = cfb_pkg::KIND_CRC;
        end
        DT_CRC_LO: begin
          res.out_byte   = crc_n[7:0];
          res.byte_kind  = cfb_pkg::KIND_CRC;
          res.frame_done = (left_q == '0);
          res.run_last   = 1'b1;
          clr_crc        = 1'b1;
          end_block      = 1'b1;
        end
        default: begin
          res.run_last = 1'b1;
        end
      endcase
    end
  end

  // hold sequencer and frame state, advance on each delivered byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      crc_q  <= '0;
      left_q <= '0;
      fill_q <= '0;
      open_q <= 1'b0;
    end else if (fire) begin
      step_q <= res.run_last ? '0 : step_q + 4'd1;
      if (clr_crc) begin
        crc_q <= '0;
      end else if (upd_crc) begin
        crc_q <= cfb_pkg::crc16_byte(crc_base, res.out_byte);
      end
      if (open_frame) begin
        left_q <= req_i.len;
        fill_q <= 5'd1;
        open_q <= 1'b1;
      end
      if (close_frame) begin
        fill_q <= '0;
        open_q <= 1'b0;
      end
      if (count_byte) begin
        left_q <= left_q - 8'd1;
        fill_q <= fill_q + 5'd1;
      end
      if (end_block) begin
        fill_q <= '0;
        if (left_q == '0) begin
          open_q <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- hdl/cfb_resq.sv -----
// Result queue between the frame sequencer and the result port.
// Depends on cfb_pkg.
module cfb_resq #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cfb_pkg::cfb_out_t item_i,
  output logic              full_o,
  output logic              empty,
  output cfb_pkg::cfb_out_t item_o,
  input  logic              pop
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cfb_pkg::cfb_out_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              wr_en, rd_en;

  assign full_o = (cnt_q == CntW'(Depth));
  assign empty  = (cnt_q == '0);
  assign wr_en  = push_i & ~full_o;
  assign rd_en  = pop & ~empty;
  assign item_o = mem_q[rd_ptr_q];

  // advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // store the result
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
